// ===== design/svrm_pkg.sv =====
// shared types and constants of the sparse voxel record map
`default_nettype none
package svrm_pkg;

   localparam int ENTRIES    = 256;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int DIV_W      = 48;
   localparam int DEN_W      = 17;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESOLUTION  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STALE_TIME  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REC_LIMIT   = 2'd3;

   localparam logic [1:0] CELL_FRONTIER = 2'd3;

   typedef enum logic [1:0] {
      OP_OBSERVE  = 2'd0,
      OP_QUERY    = 2'd1,
      OP_FRONTIER = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QLOAD,
      ST_QRUN,
      ST_FIND,
      ST_MUL,
      ST_MLOAD,
      ST_MRUN,
      ST_UPDATE,
      ST_PRUNE,
      ST_EVICT,
      ST_COUNT,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [1:0]         cell_state;
      logic [31:0]        stamp;
   } req_type;

   typedef struct packed {
      logic        observed;
      logic        is_stale;
      logic [1:0]  state_out;
      logic [31:0] age;
      logic [15:0] obs_count;
      logic [6:0]  confidence;
      logic [8:0]  count;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] key;
      logic [2:0][31:0] pos;
      logic [1:0]       state;
      logic [31:0]      stamp;
      logic [15:0]      obs;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/sparse_voxel_record_map_core.sv =====
// sparse voxel record map: slot memory, scan sequencer and serial divider
//
//  channel   ports                                 direction  transaction
//  request   start, busy, req_data                 in         start & !busy
//  response  rsp_valid, rsp_data                   out        one-cycle strobe
//  config    csr_we, csr_addr, csr_wdata           in         csr_we
//
// Every scan reads the slot memory once per slot; an observe adds one more scan for
// each record evicted over the record limit. Query and observe run the 48-step
// bit-serial divider three times for the key, and an observe that hits the key three
// times more for the running mean (six divisions).
// Reset clears valid bits and the record count at once, no clearing pass.
// The receiver cannot stall; busy stays high until the response strobe.
`default_nettype none
module sparse_voxel_record_map_core
   import svrm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire req_type               req_data,
   output logic                       busy,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // control registers
   state_type              state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [15:0]            res_ff, res_in;
   logic [31:0]            stale_ff, stale_in;
   logic [8:0]             maxrec_ff, maxrec_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [CNT_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // working registers
   req_type                req_ff, req_in;
   logic [2:0][31:0]       key_ff, key_in;
   logic [1:0]             coord_ff, coord_in;
   logic [DEN_W-1:0]       div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]       div_quo_ff, div_quo_in;
   logic [DEN_W-1:0]       div_den_ff, div_den_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   div_neg_ff, div_neg_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   entry_type              rd_data_ff;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   entry_type              hit_ent_ff, hit_ent_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   old_ff, old_in;
   logic [IDX_W-1:0]       old_idx_ff, old_idx_in;
   logic [31:0]            old_stamp_ff, old_stamp_in;
   logic signed [48:0]     prod_ff, prod_in;
   logic [2:0][31:0]       newpos_ff, newpos_in;
   logic [CNT_W-1:0]       front_ff, front_in;
   rsp_type                rsp_ff, rsp_in;

   // slot memory
   entry_type              slot_mem [ENTRIES];
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;

   // datapath helpers
   logic                   scan_issue, scan_end, rd_slot_valid, key_match;
   logic [32:0]            rd_d33, hit_d33;
   logic                   rd_stale, hit_stale;
   logic [DEN_W:0]         div_shift, div_trial;
   logic signed [31:0]     p_sel;
   logic [31:0]            p_abs;
   logic [15:0]            res_eff;
   logic [32:0]            q_dvd;
   logic [CNT_W-1:0]       limit;
   logic [15:0]            n_cur;
   logic signed [49:0]     msum;
   logic [49:0]            msum_abs;
   logic [31:0]            div_mag;
   logic [6:0]             conf;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[scan_addr_ff[IDX_W-1:0]];
   end

   // scan read-back and staleness of the slot being looked at
   assign rd_slot_valid = rd_vld_ff & valid_ff[rd_idx_ff];
   assign key_match     = (rd_data_ff.key == key_ff);
   assign rd_d33        = {1'b0, req_ff.stamp} - {1'b0, rd_data_ff.stamp};
   assign rd_stale      = (stale_ff != 32'd0) && !rd_d33[32] && (rd_d33[31:0] > stale_ff);
   assign hit_d33       = {1'b0, req_ff.stamp} - {1'b0, hit_ent_ff.stamp};
   assign hit_stale     = (stale_ff != 32'd0) && !hit_d33[32] && (hit_d33[31:0] > stale_ff);

   // restoring divider step
   assign div_shift = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_trial = div_shift - {1'b0, div_den_ff};
   assign div_mag   = div_quo_ff[31:0];

   // operand selection
   always_comb begin
      case (coord_ff)
         2'd0:    p_sel = req_ff.pos_x;
         2'd1:    p_sel = req_ff.pos_y;
         default: p_sel = req_ff.pos_z;
      endcase
   end

   assign p_abs    = p_sel[31] ? (32'd0 - p_sel) : p_sel;
   assign res_eff  = (res_ff == 16'd0) ? 16'd1 : res_ff;
   assign q_dvd    = {p_abs, 1'b0} + {17'd0, res_eff};
   assign limit    = (maxrec_ff == 9'd0) ? CNT_W'(1) : CNT_W'(maxrec_ff);
   assign n_cur    = (hit_ent_ff.obs == 16'd0) ? 16'd1 : hit_ent_ff.obs;
   assign msum     = 50'(prod_ff) + 50'(p_sel);
   assign msum_abs = msum[49] ? (50'd0 - msum) : msum;
   assign conf     = (hit_ent_ff.obs >= 16'd5) ? 7'd100
                                               : 7'd25 + 7'd15 * {4'd0, hit_ent_ff.obs[2:0]};

   assign scan_issue = !scan_addr_ff[IDX_W]
                       && ((state_ff == ST_FIND) || (state_ff == ST_PRUNE)
                           || (state_ff == ST_EVICT) || (state_ff == ST_COUNT));
   assign scan_end   = scan_addr_ff[IDX_W] && !rd_vld_ff;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      res_in       = res_ff;
      stale_in     = stale_ff;
      maxrec_in    = maxrec_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = scan_issue;
      rd_idx_in    = scan_addr_ff[IDX_W-1:0];
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      key_in       = key_ff;
      coord_in     = coord_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_stamp_in = old_stamp_ff;
      prod_in      = prod_ff;
      newpos_in    = newpos_ff;
      front_in     = front_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = hit_idx_ff;
      mem_wdata    = hit_ent_ff;

      if (scan_issue) begin
         scan_addr_in = scan_addr_ff + CNT_W'(1);
      end

      // divider iterates in its run states
      if (((state_ff == ST_QRUN) || (state_ff == ST_MRUN)) && (div_cnt_ff != '0)) begin
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         if (!div_trial[DEN_W]) begin
            div_rem_in = div_trial[DEN_W-1:0];
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_shift[DEN_W-1:0];
            div_quo_in = {div_quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               coord_in     = 2'd0;
               scan_addr_in = '0;
               front_in     = '0;
               hit_in       = 1'b0;
               case (req_data.op)
                  OP_OBSERVE, OP_QUERY: begin
                     state_in = enable_ff ? ST_QLOAD : ST_DONE;
                  end
                  OP_FRONTIER: begin
                     state_in = ST_COUNT;
                  end
                  default: begin
                     valid_in = '0;
                     total_in = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // key quantization: (2|p| + r) / 2r
         ST_QLOAD: begin
            div_rem_in = '0;
            div_quo_in = DIV_W'(q_dvd);
            div_den_in = {res_eff, 1'b0};
            div_cnt_in = DIV_CNT_W'(DIV_W);
            div_neg_in = p_sel[31];
            state_in   = ST_QRUN;
         end

         ST_QRUN: begin
            if (div_cnt_ff == '0) begin
               key_in[coord_ff] = div_neg_ff ? (32'd0 - div_mag) : div_mag;
               if (coord_ff == 2'd2) begin
                  coord_in     = 2'd0;
                  scan_addr_in = '0;
                  hit_in       = 1'b0;
                  free_in      = 1'b0;
                  old_in       = 1'b0;
                  state_in     = ST_FIND;
               end else begin
                  coord_in = coord_ff + 2'd1;
                  state_in = ST_QLOAD;
               end
            end
         end

         // key search, lowest free slot and oldest record in one pass
         ST_FIND: begin
            if (rd_slot_valid && key_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               hit_ent_in = rd_data_ff;
            end
            if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            if (rd_slot_valid && (!old_ff || (rd_data_ff.stamp < old_stamp_ff))) begin
               old_in       = 1'b1;
               old_idx_in   = rd_idx_ff;
               old_stamp_in = rd_data_ff.stamp;
            end
            if (scan_end) begin
               if (req_ff.op == OP_QUERY) begin
                  state_in = ST_DONE;
               end else if (hit_ff) begin
                  coord_in = 2'd0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end

         // running mean: (pos * n + p) / (n + 1)
         ST_MUL: begin
            prod_in  = 49'($signed(hit_ent_ff.pos[coord_ff]) * $signed({1'b0, n_cur}));
            state_in = ST_MLOAD;
         end

         ST_MLOAD: begin
            div_rem_in = '0;
            div_quo_in = msum_abs[DIV_W-1:0];
            div_den_in = {1'b0, n_cur} + DEN_W'(1);
            div_cnt_in = DIV_CNT_W'(DIV_W);
            div_neg_in = msum[49];
            state_in   = ST_MRUN;
         end

         ST_MRUN: begin
            if (div_cnt_ff == '0) begin
               newpos_in[coord_ff] = div_neg_ff ? (32'd0 - div_mag) : div_mag;
               if (coord_ff == 2'd2) begin
                  state_in = ST_UPDATE;
               end else begin
                  coord_in = coord_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end

         // write back the record, evicting the oldest when the table is full
         ST_UPDATE: begin
            mem_we          = 1'b1;
            mem_wdata.key   = key_ff;
            mem_wdata.state = req_ff.cell_state;
            mem_wdata.stamp = req_ff.stamp;
            if (hit_ff) begin
               mem_waddr     = hit_idx_ff;
               mem_wdata.pos = newpos_ff;
               mem_wdata.obs = (hit_ent_ff.obs == 16'hFFFF) ? 16'hFFFF
                                                             : hit_ent_ff.obs + 16'd1;
            end else begin
               mem_wdata.pos = {req_ff.pos_z, req_ff.pos_y, req_ff.pos_x};
               mem_wdata.obs = 16'd1;
               if (total_ff >= CNT_W'(ENTRIES)) begin
                  mem_waddr = old_idx_ff;
               end else begin
                  mem_waddr           = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  total_in            = total_ff + CNT_W'(1);
               end
            end
            scan_addr_in = '0;
            state_in     = ST_PRUNE;
         end

         // drop stale records
         ST_PRUNE: begin
            if (rd_slot_valid && rd_stale) begin
               valid_in[rd_idx_ff] = 1'b0;
               total_in            = total_ff - CNT_W'(1);
            end
            if (scan_end) begin
               scan_addr_in = '0;
               old_in       = 1'b0;
               state_in     = (total_ff > limit) ? ST_EVICT : ST_DONE;
            end
         end

         // one oldest record dropped per pass
         ST_EVICT: begin
            if (rd_slot_valid && (!old_ff || (rd_data_ff.stamp < old_stamp_ff))) begin
               old_in       = 1'b1;
               old_idx_in   = rd_idx_ff;
               old_stamp_in = rd_data_ff.stamp;
            end
            if (scan_end) begin
               valid_in[old_idx_ff] = 1'b0;
               total_in             = total_ff - CNT_W'(1);
               scan_addr_in         = '0;
               old_in               = 1'b0;
               state_in = ((total_ff - CNT_W'(1)) > limit) ? ST_EVICT : ST_DONE;
            end
         end

         // fresh frontier records
         ST_COUNT: begin
            if (rd_slot_valid && (rd_data_ff.state == CELL_FRONTIER) && !rd_stale) begin
               front_in = front_ff + CNT_W'(1);
            end
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            rsp_in       = '0;
            rsp_in.count = (req_ff.op == OP_FRONTIER) ? front_ff : total_ff;
            if ((req_ff.op == OP_QUERY) && enable_ff && hit_ff) begin
               rsp_in.observed   = 1'b1;
               rsp_in.is_stale   = hit_stale;
               rsp_in.state_out  = hit_stale ? 2'd0 : hit_ent_ff.state;
               rsp_in.age        = hit_d33[32] ? 32'd0 : hit_d33[31:0];
               rsp_in.obs_count  = hit_ent_ff.obs;
               rsp_in.confidence = hit_stale ? 7'd0 : conf;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  valid_in = '0;
                  total_in = '0;
               end
            end
            CSR_RESOLUTION:  res_in    = csr_wdata[15:0];
            CSR_STALE_TIME:  stale_in  = csr_wdata;
            CSR_REC_LIMIT:   maxrec_in = csr_wdata[8:0];
            default:         res_in    = res_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         res_ff       <= 16'd102;
         stale_ff     <= 32'd0;
         maxrec_ff    <= 9'd256;
         valid_ff     <= '0;
         total_ff     <= '0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         res_ff       <= res_in;
         stale_ff     <= stale_in;
         maxrec_ff    <= maxrec_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      key_ff       <= key_in;
      coord_ff     <= coord_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      div_neg_ff   <= div_neg_in;
      rd_idx_ff    <= rd_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ent_ff   <= hit_ent_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_ff       <= old_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
      prod_ff      <= prod_in;
      newpos_ff    <= newpos_in;
      front_ff     <= front_in;
      rsp_ff       <= rsp_in;
   end

   // record count tracks the valid bits
   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(total_ff))
      else $error("record count differs from valid bits");

   // never more records than slots
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(ENTRIES))
      else $error("record count above table size");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted without going busy");

   // a response comes only from the done step and is a single strobe
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_DONE) && !busy)
      else $error("response strobe outside the done step");

endmodule
`default_nettype wire
